[src/spcs_pkg.sv]
// ----------------------------------------------------------------------------
// Static-priority scheduler package
// Shared constants, codes, state encoding and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package spcs_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_CPUS    = 8;

    localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CW     = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int NW     = ($clog2(MAX_CPUS + 1) > 4) ? $clog2(MAX_CPUS + 1) : 4;

    // Event codes carried in the func field.
    localparam logic [2:0] EV_WAKE      = 3'd0;
    localparam logic [2:0] EV_PREEMPT   = 3'd1;
    localparam logic [2:0] EV_YIELD     = 3'd2;
    localparam logic [2:0] EV_TERMINATE = 3'd3;
    localparam logic [2:0] EV_IDLE      = 3'd4;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] cpu;
        logic [7:0] pid;
        logic [3:0] prio;
    } cmd_t;

    typedef struct packed {
        logic [7:0] id;
        logic [3:0] prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Packed so that dispatch_valid lands in bit 0.
    typedef struct packed {
        logic       ov;
        logic [2:0] pc;
        logic       pv;
        logic [7:0] dp;
        logic       dv;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_CPU_CHK,
        ST_CPU_CMP,
        ST_PRE_RD,
        ST_PRE_PUSH,
        ST_DISP,
        ST_SCAN,
        ST_SHIFT,
        ST_COMMIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[src/static_priority_cpu_scheduler.sv]
// ----------------------------------------------------------------------------
// Static-priority CPU scheduler
// Preemptive scheduler with a ready store and per-CPU running state.
// ----------------------------------------------------------------------------
// Each event transaction yields exactly one result transaction. Events are
// handled one at a time by a sequencer around two single-port-read memories.
// A wake reads the running process of every busy CPU checked before an idle
// one is found. An ignored event goes straight to its result. A dispatch reads
// every ready entry once to find the winner, then rewrites the entries behind
// it; a preempt of a busy CPU first puts its process back in the store. The
// next event is taken in the cycle after the result leaves the sequencer. The
// result sits in an output register, so the next event is taken while a
// result still waits downstream.
`default_nettype none

module static_priority_cpu_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,      // number of CPUs in use
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // cpu[2:0], process_id[10:3], priority_req[14:11]
    input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // dispatch_valid[0], dispatch_pid[8:1],
                                             // preempt_valid[9], preempt_cpu[12:10],
                                             // overflow[13]
);

    import spcs_pkg::*;

    logic [3:0] cpus_used_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg, out_data_next;

    cmd_t       cmd;
    logic       res_valid, res_take;
    result_t    res;

    assign cmd = '{func: s_axis_tuser,
                   cpu:  s_axis_tdata[2:0],
                   pid:  s_axis_tdata[10:3],
                   prio: s_axis_tdata[14:11]};

    spcs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .cpus_used (cpus_used_reg),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpus_used_reg <= 4'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cpus_used_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg};

endmodule

`default_nettype wire

[src/spcs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/spcs_engine.sv]
// ----------------------------------------------------------------------------
// Scheduler engine
// Sequencer that reads, modifies and writes back the ready store and the
// per-CPU running-process memory.
// ----------------------------------------------------------------------------
`default_nettype none

module spcs_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire spcs_pkg::cmd_t   cmd,
    input  wire logic [3:0]       cpus_used,
    output logic                  res_valid,
    input  wire logic             res_take,
    output spcs_pkg::result_t     res
);

    import spcs_pkg::*;

    state_t state_reg, state_next;

    cmd_t                 cmd_reg, cmd_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [MAX_CPUS-1:0]  busy_reg, busy_next;
    result_t              res_reg, res_next;

    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 pend_reg, pend_next;
    logic [QW-1:0]        pend_idx_reg, pend_idx_next;
    logic [QW-1:0]        best_idx_reg, best_idx_next;
    entry_t               best_reg, best_next;

    logic [NW-1:0]        k_reg, k_next;
    logic [3:0]           lowest_reg, lowest_next;
    logic [CW-1:0]        target_reg, target_next;
    logic                 found_reg, found_next;

    // Memory ports
    logic                 q_we;
    logic [QW-1:0]        q_waddr, q_raddr;
    entry_t               q_wdata, q_rdata;
    logic [ENTRY_W-1:0]   q_rdata_raw;
    logic                 c_we;
    logic [CW-1:0]        c_waddr, c_raddr;
    entry_t               c_rdata;
    logic [ENTRY_W-1:0]   c_rdata_raw;

    logic [NW-1:0]        n_cur;
    logic                 in_c_ok, in_busy;
    logic [CW-1:0]        c_idx;
    logic                 k_ok, k_busy;
    logic                 issue, store_full;

    assign n_cur   = (NW'(cpus_used) > NW'(MAX_CPUS)) ? NW'(MAX_CPUS) : NW'(cpus_used);
    assign in_c_ok = NW'(cmd.cpu) < n_cur;
    assign in_busy = in_c_ok && busy_reg[CW'(cmd.cpu)];
    assign c_idx   = CW'(cmd_reg.cpu);
    assign k_ok    = k_reg < n_reg;
    assign k_busy  = k_ok && busy_reg[CW'(k_reg)];
    assign issue   = rd_idx_reg < count_reg;
    assign store_full = count_reg == CNT_W'(QUEUE_DEPTH);

    assign q_rdata = entry_t'(q_rdata_raw);
    assign c_rdata = entry_t'(c_rdata_raw);

    spcs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ready_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata_raw)
    );

    spcs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CPUS)) u_cpu_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata ({best_reg}),
        .raddr (c_raddr),
        .rdata (c_rdata_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            busy_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        n_reg        <= n_next;
        res_reg      <= res_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        k_reg        <= k_next;
        lowest_reg   <= lowest_next;
        target_reg   <= target_next;
        found_reg    <= found_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.func == EV_WAKE)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (cmd.func > EV_IDLE || !in_c_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        case (cmd.func) inside
                            EV_PREEMPT:              state_next = in_busy ? ST_PRE_RD : ST_DISP;
                            EV_YIELD, EV_TERMINATE:  state_next = ST_DISP;
                            default:                 state_next = in_busy ? ST_DONE : ST_DISP;
                        endcase
                    end
                end
            end
            ST_PUSH:     state_next = ST_CPU_CHK;
            ST_CPU_CHK:  state_next = (!k_ok || !k_busy) ? ST_DONE : ST_CPU_CMP;
            ST_CPU_CMP:  state_next = ST_CPU_CHK;
            ST_PRE_RD:   state_next = ST_PRE_PUSH;
            ST_PRE_PUSH: state_next = ST_DISP;
            ST_DISP:     state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
            ST_SCAN:     state_next = (!issue && !pend_reg) ? ST_SHIFT : ST_SCAN;
            ST_SHIFT:    state_next = (!issue && !pend_reg) ? ST_COMMIT : ST_SHIFT;
            ST_COMMIT:   state_next = ST_DONE;
            ST_DONE:     state_next = res_take ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        cmd_next      = cmd_reg;
        n_next        = n_reg;
        count_next    = count_reg;
        busy_next     = busy_reg;
        res_next      = res_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        k_next        = k_reg;
        lowest_next   = lowest_reg;
        target_next   = target_reg;
        found_next    = found_reg;

        q_we    = 1'b0;
        q_waddr = count_reg[QW-1:0];
        q_wdata = '{id: cmd_reg.pid, prio: cmd_reg.prio};
        q_raddr = rd_idx_reg[QW-1:0];
        c_we    = 1'b0;
        c_waddr = c_idx;
        c_raddr = c_idx;

        cmd_ready = state_reg == ST_IDLE;
        res_valid = state_reg == ST_DONE;
        res       = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    n_next      = n_cur;
                    res_next    = '0;
                    k_next      = '0;
                    lowest_next = cmd.prio;
                    target_next = '0;
                    found_next  = 1'b0;
                    if ((cmd.func == EV_YIELD || cmd.func == EV_TERMINATE) && in_c_ok)
                    begin
                        busy_next[CW'(cmd.cpu)] = 1'b0;
                    end
                end
            end
            ST_PUSH:
            begin
                if (store_full)
                begin
                    res_next.ov = 1'b1;
                end
                else
                begin
                    q_we       = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            ST_CPU_CHK:
            begin
                c_raddr = CW'(k_reg);
                if (k_ok && !k_busy)
                begin
                    res_next.pv = 1'b1;
                    res_next.pc = 3'(CW'(k_reg));
                end
                else if (!k_ok)
                begin
                    res_next.pv = found_reg;
                    res_next.pc = 3'(target_reg);
                end
            end
            ST_CPU_CMP:
            begin
                if (c_rdata.prio < lowest_reg)
                begin
                    lowest_next = c_rdata.prio;
                    target_next = CW'(k_reg);
                    found_next  = 1'b1;
                end
                k_next = k_reg + 1'b1;
            end
            ST_PRE_RD:
            begin
                c_raddr = c_idx;
            end
            ST_PRE_PUSH:
            begin
                q_wdata = c_rdata;
                if (store_full)
                begin
                    res_next.ov = 1'b1;
                end
                else
                begin
                    q_we       = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            ST_DISP:
            begin
                rd_idx_next = '0;
                if (count_reg == '0)
                begin
                    busy_next[c_idx] = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // Reads stream one per cycle; each returns in the next cycle.
                if (issue)
                begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[QW-1:0];
                end
                if (pend_reg && (pend_idx_reg == '0 || q_rdata.prio > best_reg.prio))
                begin
                    best_idx_next = pend_idx_reg;
                    best_next     = q_rdata;
                end
                if (!issue && !pend_reg)
                begin
                    rd_idx_next = CNT_W'(best_idx_reg) + 1'b1;
                end
            end
            ST_SHIFT:
            begin
                // Each entry past the winner moves down one place.
                if (issue)
                begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[QW-1:0];
                end
                if (pend_reg)
                begin
                    q_we    = 1'b1;
                    q_waddr = pend_idx_reg - 1'b1;
                    q_wdata = q_rdata;
                end
            end
            ST_COMMIT:
            begin
                count_next       = count_reg - 1'b1;
                c_we             = 1'b1;
                busy_next[c_idx] = 1'b1;
                res_next.dv      = 1'b1;
                res_next.dp      = best_reg.id;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
